// ===== rtl/prca_pkg.sv =====
// ----------------------------------------------------------------------------
// prca_pkg: shared definitions of the page refcount allocator
// Field widths, request and status codes, and the result record.
// ----------------------------------------------------------------------------
package prca_pkg;

	// Default sizing of the page table.
	localparam int NUM_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths.
	localparam int ADDR_W   = 27;
	localparam int LEN_W    = 28;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 3;
	localparam int SUM_W    = 16;
	localparam int CFG_W    = 16;

	// Reset value of the pages-in-use register.
	localparam logic [CFG_W-1:0] PAGES_IN_USE_RESET = 16'd32768;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_MARK   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INCREF = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DECREF = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OOR       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_REFS   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd5;

	// One result record.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   alloc_addr;
		logic [SUM_W-1:0]    total_pages;
		logic [SUM_W-1:0]    used_pages;
		logic [SUM_W-1:0]    reserved_pages;
	} rsp_t;

endpackage

// ===== rtl/prca_if.sv =====
// ----------------------------------------------------------------------------
// prca_if: channel interfaces of the page refcount allocator
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel.
interface prca_req_if;
	logic                          valid;
	logic                          ready;
	logic [prca_pkg::REQ_W-1:0]    req_type;
	logic [prca_pkg::ADDR_W-1:0]   page_addr;
	logic [prca_pkg::ADDR_W-1:0]   region_base;
	logic [prca_pkg::LEN_W-1:0]    region_len;
	logic                          region_is_memory;

	modport source (output valid, req_type, page_addr, region_base, region_len,
		region_is_memory, input ready);
	modport sink (input valid, req_type, page_addr, region_base, region_len,
		region_is_memory, output ready);
endinterface

// Response channel.
interface prca_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [prca_pkg::STATUS_W-1:0] status;
	logic [prca_pkg::ADDR_W-1:0]   alloc_addr;
	logic [prca_pkg::SUM_W-1:0]    total_pages;
	logic [prca_pkg::SUM_W-1:0]    used_pages;
	logic [prca_pkg::SUM_W-1:0]    reserved_pages;

	modport source (output valid, status, alloc_addr, total_pages, used_pages,
		reserved_pages, input ready);
	modport sink (input valid, status, alloc_addr, total_pages, used_pages,
		reserved_pages, output ready);
endinterface

// Configuration write channel.
interface prca_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [prca_pkg::CFG_W-1:0]  pages_in_use;

	modport source (output valid, pages_in_use, input ready);
	modport sink (input valid, pages_in_use, output ready);
endinterface

// ===== rtl/prca_ram.sv =====
// ----------------------------------------------------------------------------
// prca_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prca_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/page_refcount_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_refcount_allocator_top: reference-counted page frame allocator
// Keeps present bit and reference count per page in one table RAM.
// ----------------------------------------------------------------------------
// Incref and decref read the table entry, then modify and write it back.
// Mark region makes one table write per cycle, one for each page marked.
// Alloc and count query scan at most pages_in_use entries, one table read
// per cycle through the single read port. Results leave through an output
// register. After reset a clearing pass writes every table entry, during
// which requests wait and configuration writes are taken.
module page_refcount_allocator_top #(
	parameter int NUM_PAGES  = prca_pkg::NUM_PAGES_DEF,
	parameter int PAGE_BYTES = prca_pkg::PAGE_BYTES_DEF,
	parameter int COUNT_BITS = prca_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	prca_req_if.sink   req,
	prca_rsp_if.source rsp,
	prca_cfg_if.sink   cfg
);

	localparam int IDX_W      = $clog2(NUM_PAGES);
	localparam int CNT_W      = $clog2(NUM_PAGES + 1);
	localparam int ENTRY_W    = COUNT_BITS + 1;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int ADDR_W     = prca_pkg::ADDR_W;
	localparam int LEN_W      = prca_pkg::LEN_W;
	localparam int SUM_W      = prca_pkg::SUM_W;

	localparam logic [ADDR_W:0]    ROUND_UP    = (ADDR_W + 1)'(PAGE_BYTES - 1);
	localparam logic [31:0]        NUM_PAGES_W = 32'(NUM_PAGES);
	localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(NUM_PAGES - 1);
	localparam logic [CNT_W-1:0]   NUM_PAGES_C = CNT_W'(NUM_PAGES);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MODIFY,
		S_MARK,
		S_SCAN,
		S_OUT
	} state_t;

	// Saturating increment of a count-query sum.
	function automatic logic [SUM_W-1:0] sat_inc(input logic [SUM_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	state_t                       state_q;
	logic [CNT_W-1:0]             walk_q;
	logic [CNT_W-1:0]             end_q;
	logic [prca_pkg::REQ_W-1:0]   req_q;
	logic [IDX_W-1:0]             idx_q;
	logic                         oor_q;
	logic [prca_pkg::STATUS_W-1:0] status_q;
	logic                         vld_s1;
	logic [CNT_W-1:0]             idx_s1;
	logic [SUM_W-1:0]             total_q;
	logic [SUM_W-1:0]             used_q;
	logic [SUM_W-1:0]             resv_q;
	prca_pkg::rsp_t               res_q;
	prca_pkg::rsp_t               out_q;
	logic                         out_valid_q;
	logic [prca_pkg::CFG_W-1:0]   piu_q;

	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr;
	logic [ENTRY_W-1:0]           ram_wdata;
	logic                         ram_re;
	logic [IDX_W-1:0]             ram_raddr;
	logic [ENTRY_W-1:0]           ram_rdata;

	logic                         ent_present;
	logic [COUNT_BITS-1:0]        ent_count;
	logic [ADDR_W:0]              idx_sum;
	logic [31:0]                  idx_w;
	logic                         idx_oor;
	logic [ADDR_W:0]              first_sum;
	logic [LEN_W:0]               last_sum;
	logic [31:0]                  first_w;
	logic [31:0]                  last_w;
	logic [31:0]                  stop_w;
	logic                         has_pages;
	logic                         over_end;
	logic                         mark_any;
	logic [CNT_W-1:0]             mark_start;
	logic [CNT_W-1:0]             mark_stop;
	logic [CNT_W-1:0]             scan_lim;
	logic                         issue;
	logic                         found;
	logic                         fin;
	prca_pkg::rsp_t               fin_rsp;
	logic                         out_free;
	logic [63:0]                  addr_full;

	assign ent_present = ram_rdata[COUNT_BITS];
	assign ent_count   = ram_rdata[COUNT_BITS-1:0];

	// Handshake signals.
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.alloc_addr     = out_q.alloc_addr;
	assign rsp.total_pages    = out_q.total_pages;
	assign rsp.used_pages     = out_q.used_pages;
	assign rsp.reserved_pages = out_q.reserved_pages;

	// Page index of an incref or decref address, rounded up.
	assign idx_sum = {1'b0, req.page_addr} + ROUND_UP;
	assign idx_w   = 32'(idx_sum >> PAGE_SHIFT);
	assign idx_oor = (idx_w >= NUM_PAGES_W);

	// Whole pages of a region, clipped to the table.
	assign first_sum  = {1'b0, req.region_base} + ROUND_UP;
	assign last_sum   = (LEN_W + 1)'(req.region_base) + (LEN_W + 1)'(req.region_len);
	assign first_w    = 32'(first_sum >> PAGE_SHIFT);
	assign last_w     = 32'(last_sum >> PAGE_SHIFT);
	assign over_end   = (last_w > NUM_PAGES_W);
	assign stop_w     = over_end ? NUM_PAGES_W : last_w;
	assign has_pages  = req.region_is_memory && (first_w < last_w);
	assign mark_any   = has_pages && (first_w < stop_w);
	assign mark_start = mark_any ? CNT_W'(first_w) : '0;
	assign mark_stop  = mark_any ? CNT_W'(stop_w) : '0;

	// Scan limit is pages_in_use clipped to the table size.
	assign scan_lim = (32'(piu_q) > NUM_PAGES_W) ? NUM_PAGES_C : CNT_W'(piu_q);

	// Scan control.
	assign issue     = (walk_q < end_q);
	assign found     = vld_s1 && (req_q == prca_pkg::REQ_ALLOC) && ent_present
		&& (ent_count == '0);
	assign addr_full = 64'(idx_s1) << PAGE_SHIFT;

	// Table access and result of the finishing cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		fin       = 1'b0;
		fin_rsp   = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = walk_q[IDX_W-1:0];
			end
			S_IDLE: begin
				ram_re    = req.valid && !idx_oor && (req.req_type == prca_pkg::REQ_INCREF
					|| req.req_type == prca_pkg::REQ_DECREF);
				ram_raddr = idx_w[IDX_W-1:0];
			end
			S_MODIFY: begin
				fin       = 1'b1;
				ram_waddr = idx_q;
				if (oor_q) begin
					fin_rsp.status = prca_pkg::ST_OOR;
				end else if (!ent_present) begin
					fin_rsp.status = prca_pkg::ST_ABSENT;
				end else if (req_q == prca_pkg::REQ_INCREF) begin
					if (ent_count == '1) begin
						fin_rsp.status = prca_pkg::ST_SATURATED;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, COUNT_BITS'(ent_count + 1'b1)};
					end
				end else begin
					if (ent_count == '0) begin
						fin_rsp.status = prca_pkg::ST_NO_REFS;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, COUNT_BITS'(ent_count - 1'b1)};
					end
				end
			end
			S_MARK: begin
				if (issue) begin
					ram_we    = 1'b1;
					ram_waddr = walk_q[IDX_W-1:0];
					ram_wdata = {1'b1, COUNT_BITS'(0)};
				end else begin
					fin            = 1'b1;
					fin_rsp.status = status_q;
				end
			end
			S_SCAN: begin
				ram_re    = issue;
				ram_raddr = walk_q[IDX_W-1:0];
				if (found) begin
					// First free page: take it with one reference.
					ram_we             = 1'b1;
					ram_waddr          = idx_s1[IDX_W-1:0];
					ram_wdata          = {1'b1, COUNT_BITS'(1)};
					fin                = 1'b1;
					fin_rsp.alloc_addr = addr_full[ADDR_W-1:0];
				end else if (!issue && !vld_s1) begin
					fin = 1'b1;
					if (req_q == prca_pkg::REQ_ALLOC) begin
						fin_rsp.status = prca_pkg::ST_NO_FREE;
					end else begin
						fin_rsp.total_pages    = total_q;
						fin_rsp.used_pages     = used_q;
						fin_rsp.reserved_pages = resv_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, scan pipeline, result and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			walk_q      <= '0;
			end_q       <= '0;
			req_q       <= prca_pkg::REQ_MARK;
			idx_q       <= '0;
			oor_q       <= 1'b0;
			status_q    <= prca_pkg::ST_OK;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			total_q     <= '0;
			used_q      <= '0;
			resv_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			piu_q       <= prca_pkg::PAGES_IN_USE_RESET;
		end else begin
			if (cfg.valid) begin
				piu_q <= cfg.pages_in_use;
			end
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// A finished result goes to the output register, or waits in res_q.
			if (fin) begin
				if (out_free) begin
					out_q       <= fin_rsp;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end else begin
					res_q   <= fin_rsp;
					state_q <= S_OUT;
				end
			end

			case (state_q)
				S_CLEAR: begin
					if (walk_q[IDX_W-1:0] == LAST_IDX) begin
						walk_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						req_q <= req.req_type;
						case (req.req_type)
							prca_pkg::REQ_INCREF, prca_pkg::REQ_DECREF: begin
								idx_q   <= idx_w[IDX_W-1:0];
								oor_q   <= idx_oor;
								state_q <= S_MODIFY;
							end
							prca_pkg::REQ_MARK: begin
								walk_q   <= mark_start;
								end_q    <= mark_stop;
								status_q <= (has_pages && over_end) ? prca_pkg::ST_OOR
									: prca_pkg::ST_OK;
								state_q  <= S_MARK;
							end
							prca_pkg::REQ_ALLOC, prca_pkg::REQ_COUNT: begin
								walk_q  <= '0;
								end_q   <= scan_lim;
								vld_s1  <= 1'b0;
								total_q <= '0;
								used_q  <= '0;
								resv_q  <= '0;
								state_q <= S_SCAN;
							end
							default: begin
								// Unknown request: an empty walk that reports out of range.
								walk_q   <= '0;
								end_q    <= '0;
								status_q <= prca_pkg::ST_OOR;
								state_q  <= S_MARK;
							end
						endcase
					end
				end
				S_MARK: begin
					if (issue) begin
						walk_q <= walk_q + 1'b1;
					end
				end
				S_SCAN: begin
					vld_s1 <= issue;
					idx_s1 <= walk_q;
					if (issue) begin
						walk_q <= walk_q + 1'b1;
					end
					if (vld_s1 && req_q == prca_pkg::REQ_COUNT) begin
						if (ent_present) begin
							total_q <= sat_inc(total_q);
							if (ent_count != '0) begin
								used_q <= sat_inc(used_q);
							end
						end else begin
							resv_q <= sat_inc(resv_q);
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Page table: present bit over reference count.
	prca_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_PAGES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the page refcount allocator
// Drives page requests and configuration writes through the channel
// interfaces and keeps a shadow page table that predicts every response.
// A short table of directed requests covers the corner cases. Random
// request streams follow under several pages-in-use settings and several
// patterns of source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT      = 5000000;
	localparam int DRAIN_TAIL       = 40;
	localparam int ITEMS_PER_PHASE  = 205;
	localparam int NUM_PHASES       = 8;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int NUM_PAGES        = prca_pkg::NUM_PAGES_DEF;
	localparam int PAGE_BYTES       = prca_pkg::PAGE_BYTES_DEF;
	localparam int COUNT_MAX        = (1 << prca_pkg::COUNT_BITS_DEF) - 1;
	localparam int SUM_MAX          = (1 << prca_pkg::SUM_W) - 1;

	localparam logic [prca_pkg::REQ_W-1:0]  REQ_UNKNOWN_LO = 3'd5;
	localparam logic [prca_pkg::REQ_W-1:0]  REQ_UNKNOWN_HI = 3'd7;
	localparam logic [prca_pkg::ADDR_W-1:0] ADDR_MAX       = 27'h7FF_FFFF;
	localparam logic [prca_pkg::ADDR_W-1:0] TOP_BASE       = 27'h7F0_0000;
	localparam logic [prca_pkg::LEN_W-1:0]  LEN_MAX        = 28'hFFF_FFFF;
	localparam logic [prca_pkg::LEN_W-1:0]  TABLE_BYTES    = 28'h800_0000;

	typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	// One request as it travels on the request channel.
	typedef struct packed {
		logic [prca_pkg::REQ_W-1:0]  req_type;
		logic [prca_pkg::ADDR_W-1:0] page_addr;
		logic [prca_pkg::ADDR_W-1:0] region_base;
		logic [prca_pkg::LEN_W-1:0]  region_len;
		logic                        region_is_memory;
	} page_req_t;

	// A response fixed in the stimulus table overrides the prediction.
	typedef struct packed {
		bit             pinned;
		prca_pkg::rsp_t result;
	} pinned_rsp_t;

	typedef struct {
		bit                         is_cfg;
		logic [prca_pkg::CFG_W-1:0] cfg_value;
		page_req_t                  item;
		int                         reps;
		bit                         pinned;
		prca_pkg::rsp_t             result;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prca_req_if req_ch ();
	prca_rsp_if rsp_ch ();
	prca_cfg_if cfg_ch ();

	page_refcount_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow page table and pages-in-use register.
	bit                         page_present [NUM_PAGES];
	int unsigned                page_refs [NUM_PAGES];
	logic [prca_pkg::CFG_W-1:0] pages_in_use_reg = prca_pkg::PAGES_IN_USE_RESET;

	prca_pkg::rsp_t expected_rsp_q [$];
	pinned_rsp_t    pinned_rsp_q [$];
	int             mismatch_count = 0;

	// Source and sink pacing; the sink hold-off is requested by ticket.
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int          hold_len = 0;
	int          hold_ticket = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	int unsigned phase_pages [NUM_PHASES] = '{24, 1, 64, 7, 256, 40, 16, 100};

	always begin
		#4;
		clk = 1'b1;
		#4;
		clk = 1'b0;
	end

	// Apply one request to the shadow table and return its response.
	function automatic prca_pkg::rsp_t apply_page_request(page_req_t r);
		prca_pkg::rsp_t  res;
		longint unsigned base, len, first_pg, last_pg, stop_pg, idx, lim;
		longint unsigned tot, used, resv;
		res = '0;
		base = r.region_base;
		len = r.region_len;
		lim = (pages_in_use_reg > NUM_PAGES) ? NUM_PAGES : pages_in_use_reg;
		tot = 0;
		used = 0;
		resv = 0;
		case (r.req_type)
		prca_pkg::REQ_MARK: begin
			if (r.region_is_memory) begin
				first_pg = (base + PAGE_BYTES - 1) / PAGE_BYTES;
				last_pg = (base + len) / PAGE_BYTES;
				if (first_pg < last_pg) begin
					stop_pg = last_pg;
					if (stop_pg > NUM_PAGES) begin
						stop_pg = NUM_PAGES;
						res.status = prca_pkg::ST_OOR;
					end
					for (idx = first_pg; idx < stop_pg; idx++) begin
						page_present[idx] = 1'b1;
						page_refs[idx] = 0;
					end
				end
			end
		end
		prca_pkg::REQ_INCREF, prca_pkg::REQ_DECREF: begin
			idx = (longint'(r.page_addr) + PAGE_BYTES - 1) / PAGE_BYTES;
			if (idx >= NUM_PAGES)
				res.status = prca_pkg::ST_OOR;
			else if (!page_present[idx])
				res.status = prca_pkg::ST_ABSENT;
			else if (r.req_type == prca_pkg::REQ_INCREF) begin
				if (page_refs[idx] >= COUNT_MAX)
					res.status = prca_pkg::ST_SATURATED;
				else
					page_refs[idx]++;
			end else begin
				if (page_refs[idx] == 0)
					res.status = prca_pkg::ST_NO_REFS;
				else
					page_refs[idx]--;
			end
		end
		prca_pkg::REQ_ALLOC: begin
			// First fit among the scanned pages.
			res.status = prca_pkg::ST_NO_FREE;
			for (idx = 0; idx < lim && res.status == prca_pkg::ST_NO_FREE; idx++) begin
				if (page_present[idx] && page_refs[idx] == 0) begin
					page_refs[idx] = 1;
					res.alloc_addr = prca_pkg::ADDR_W'(idx * PAGE_BYTES);
					res.status = prca_pkg::ST_OK;
				end
			end
		end
		prca_pkg::REQ_COUNT: begin
			for (idx = 0; idx < lim; idx++) begin
				if (page_present[idx]) begin
					tot++;
					if (page_refs[idx] != 0)
						used++;
				end else begin
					resv++;
				end
			end
			res.total_pages = prca_pkg::SUM_W'((tot > SUM_MAX) ? SUM_MAX : tot);
			res.used_pages = prca_pkg::SUM_W'((used > SUM_MAX) ? SUM_MAX : used);
			res.reserved_pages = prca_pkg::SUM_W'((resv > SUM_MAX) ? SUM_MAX : resv);
		end
		default: begin
			res.status = prca_pkg::ST_OOR;
		end
		endcase
		return res;
	endfunction

	// Predict on every accepted request, check every accepted response.
	always @(posedge clk) begin : result_check
		pinned_rsp_t    tag;
		prca_pkg::rsp_t want;
		prca_pkg::rsp_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				pages_in_use_reg = cfg_ch.pages_in_use;
			if (req_ch.valid && req_ch.ready) begin
				tag = pinned_rsp_q.pop_front();
				want = apply_page_request({req_ch.req_type, req_ch.page_addr,
					req_ch.region_base, req_ch.region_len, req_ch.region_is_memory});
				if (tag.pinned)
					want = tag.result;
				expected_rsp_q.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.status, rsp_ch.alloc_addr, rsp_ch.total_pages,
					rsp_ch.used_pages, rsp_ch.reserved_pages};
				if (expected_rsp_q.size() == 0) begin
					$error("response with no request outstanding: status %0d", got.status);
					mismatch_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatch_count++;
					end
					if (got.alloc_addr !== want.alloc_addr) begin
						$error("alloc_addr: expected 0x%0h, got 0x%0h",
							want.alloc_addr, got.alloc_addr);
						mismatch_count++;
					end
					if (got.total_pages !== want.total_pages) begin
						$error("total_pages: expected %0d, got %0d",
							want.total_pages, got.total_pages);
						mismatch_count++;
					end
					if (got.used_pages !== want.used_pages) begin
						$error("used_pages: expected %0d, got %0d",
							want.used_pages, got.used_pages);
						mismatch_count++;
					end
					if (got.reserved_pages !== want.reserved_pages) begin
						$error("reserved_pages: expected %0d, got %0d",
							want.reserved_pages, got.reserved_pages);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Response ready: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen = hold_ticket;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Run limit.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic dir_row_t op_row(logic [prca_pkg::REQ_W-1:0] kind,
		logic [prca_pkg::ADDR_W-1:0] addr, logic [prca_pkg::ADDR_W-1:0] base,
		logic [prca_pkg::LEN_W-1:0] len, bit mem, int reps = 1);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_value = '0;
		row.item = {kind, addr, base, len, mem};
		row.reps = reps;
		row.pinned = 1'b0;
		row.result = '0;
		return row;
	endfunction

	// Totals and used counts are zero in every pinned row.
	function automatic dir_row_t pinned_row(logic [prca_pkg::REQ_W-1:0] kind,
		logic [prca_pkg::ADDR_W-1:0] addr, logic [prca_pkg::ADDR_W-1:0] base,
		logic [prca_pkg::LEN_W-1:0] len, bit mem,
		logic [prca_pkg::STATUS_W-1:0] st, logic [prca_pkg::SUM_W-1:0] resv = '0);
		dir_row_t row;
		row = op_row(kind, addr, base, len, mem);
		row.pinned = 1'b1;
		row.result.status = st;
		row.result.reserved_pages = resv;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(logic [prca_pkg::CFG_W-1:0] value);
		dir_row_t row;
		row = op_row(prca_pkg::REQ_MARK, '0, '0, '0, 1'b0, 0);
		row.is_cfg = 1'b1;
		row.cfg_value = value;
		return row;
	endfunction

	// Random request: mostly well-formed requests on pages near the scanned
	// range, with junk in the fields that the request does not use.
	function automatic page_req_t draw_page_request(int unsigned span);
		page_req_t   r;
		int unsigned pick, pg;
		r.req_type = prca_pkg::REQ_MARK;
		r.page_addr = prca_pkg::ADDR_W'($urandom);
		r.region_base = prca_pkg::ADDR_W'($urandom);
		r.region_len = prca_pkg::LEN_W'($urandom);
		r.region_is_memory = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		pg = $urandom_range(0, span - 1);
		if (pick < 12) begin
			r.region_is_memory = 1'b1;
			case ($urandom_range(0, 9))
			0: r.region_is_memory = 1'b0;
			// Region that runs off the end of the table.
			1: r.region_base = prca_pkg::ADDR_W'($urandom_range(TOP_BASE, ADDR_MAX));
			// Small region anywhere.
			2: r.region_len = prca_pkg::LEN_W'($urandom_range(0, 32'h8000));
			default: begin
				r.region_base = prca_pkg::ADDR_W'(pg * PAGE_BYTES +
					(($urandom_range(0, 3) == 0) ? $urandom_range(1, PAGE_BYTES - 1) : 0));
				r.region_len = prca_pkg::LEN_W'($urandom_range(0, 6) * PAGE_BYTES +
					($urandom_range(0, 1) ? $urandom_range(0, PAGE_BYTES - 1) : 0));
			end
			endcase
		end else if (pick < 72) begin
			r.req_type = (pick < 42) ? prca_pkg::REQ_INCREF : prca_pkg::REQ_DECREF;
			// One in twenty keeps the full random address.
			if ($urandom_range(0, 19) != 0) begin
				if (pg > 0 && $urandom_range(0, 1))
					r.page_addr = prca_pkg::ADDR_W'(pg * PAGE_BYTES -
						$urandom_range(0, PAGE_BYTES - 1));
				else
					r.page_addr = prca_pkg::ADDR_W'(pg * PAGE_BYTES);
			end
		end else if (pick < 84) begin
			r.req_type = prca_pkg::REQ_ALLOC;
		end else if (pick < 96) begin
			r.req_type = prca_pkg::REQ_COUNT;
		end else begin
			r.req_type = prca_pkg::REQ_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
		end
		return r;
	endfunction

	task automatic set_idle(idle_mode_t mode);
		case (mode)
		IDLE_NONE: begin
			src_idle_pct = 0;
			sink_stall_pct <= 0;
		end
		IDLE_SOURCE: begin
			src_idle_pct = 58;
			sink_stall_pct <= 0;
		end
		IDLE_SINK: begin
			src_idle_pct = 0;
			sink_stall_pct <= 58;
		end
		default: begin
			src_idle_pct = 8;
			sink_stall_pct <= 8;
		end
		endcase
	endtask

	// Offer one request and return at the edge that accepts it.
	task automatic send_page_request(page_req_t r, bit pinned, prca_pkg::rsp_t result);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pinned_rsp_q.push_back({pinned, result});
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.req_type;
		req_ch.page_addr <= r.page_addr;
		req_ch.region_base <= r.region_base;
		req_ch.region_len <= r.region_len;
		req_ch.region_is_memory <= r.region_is_memory;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering requests and wait for every outstanding response.
	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_rsp_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_pages_in_use(logic [prca_pkg::CFG_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.pages_in_use <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		dir_row_t  dir_rows [$];
		int        n;
		int        phase;
		page_req_t r;
		req_ch.valid = 1'b0;
		req_ch.req_type = prca_pkg::REQ_MARK;
		req_ch.page_addr = '0;
		req_ch.region_base = '0;
		req_ch.region_len = '0;
		req_ch.region_is_memory = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.pages_in_use = '0;
		rsp_ch.ready = 1'b0;

		dir_rows = '{
			cfg_row(16'd32768),
			// Empty table right after reset.
			pinned_row(prca_pkg::REQ_COUNT, '0, '0, '0, 1'b0, prca_pkg::ST_OK, 16'd32768),
			pinned_row(prca_pkg::REQ_ALLOC, ADDR_MAX, ADDR_MAX, LEN_MAX, 1'b1,
				prca_pkg::ST_NO_FREE),
			pinned_row(prca_pkg::REQ_INCREF, '0, '0, '0, 1'b0, prca_pkg::ST_ABSENT),
			pinned_row(prca_pkg::REQ_DECREF, ADDR_MAX, '0, '0, 1'b0, prca_pkg::ST_OOR),
			pinned_row(REQ_UNKNOWN_HI, ADDR_MAX, ADDR_MAX, LEN_MAX, 1'b1, prca_pkg::ST_OOR),
			pinned_row(REQ_UNKNOWN_LO, '0, '0, '0, 1'b0, prca_pkg::ST_OOR),
			// Region marking corners: not memory, empty, past the end.
			pinned_row(prca_pkg::REQ_MARK, '0, '0, TABLE_BYTES, 1'b0, prca_pkg::ST_OK),
			pinned_row(prca_pkg::REQ_MARK, '0, 27'h1001, 28'd100, 1'b1, prca_pkg::ST_OK),
			pinned_row(prca_pkg::REQ_MARK, '0, ADDR_MAX, LEN_MAX, 1'b1, prca_pkg::ST_OOR),
			pinned_row(prca_pkg::REQ_MARK, '0, 27'h7FF_0000, TABLE_BYTES, 1'b1,
				prca_pkg::ST_OOR),
			op_row(prca_pkg::REQ_MARK, '0, '0, 28'h5000, 1'b1),
			cfg_row(16'd16),
			op_row(prca_pkg::REQ_ALLOC, '0, '0, '0, 1'b0),
			op_row(prca_pkg::REQ_INCREF, 27'd1, '0, '0, 1'b0),
			op_row(prca_pkg::REQ_INCREF, 27'h1000, '0, '0, 1'b0),
			pinned_row(prca_pkg::REQ_DECREF, 27'h1001, '0, '0, 1'b0, prca_pkg::ST_NO_REFS),
			op_row(prca_pkg::REQ_DECREF, 27'h1000, '0, '0, 1'b0),
			// Marking pages that are in use clears their counts.
			op_row(prca_pkg::REQ_MARK, '0, '0, 28'h2000, 1'b1),
			op_row(prca_pkg::REQ_COUNT, '0, '0, '0, 1'b0),
			// Stack several references on one page, then drop one.
			op_row(prca_pkg::REQ_INCREF, 27'h3000, '0, '0, 1'b0, 4),
			op_row(prca_pkg::REQ_DECREF, 27'h3000, '0, '0, 1'b0),
			cfg_row(16'd0),
			pinned_row(prca_pkg::REQ_ALLOC, '0, '0, '0, 1'b0, prca_pkg::ST_NO_FREE),
			pinned_row(prca_pkg::REQ_COUNT, '0, '0, '0, 1'b0, prca_pkg::ST_OK),
			cfg_row(16'hFFFF),
			op_row(prca_pkg::REQ_COUNT, '0, '0, '0, 1'b0),
			cfg_row(16'd1),
			op_row(prca_pkg::REQ_ALLOC, '0, '0, '0, 1'b0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests with no idling.
		set_idle(IDLE_NONE);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_results_drained();
				write_pages_in_use(dir_rows[i].cfg_value);
			end else begin
				for (n = 0; n < dir_rows[i].reps; n++)
					send_page_request(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].result);
			end
		end

		// Random request streams, one pages-in-use setting per phase.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			wait_results_drained();
			set_idle(idle_mode_t'(phase % 4));
			write_pages_in_use(prca_pkg::CFG_W'(phase_pages[phase]));
			// The sink holds off while requests keep coming, so the block backs up.
			if (phase == 0) begin
				hold_len <= LONG_HOLD_CYCLES;
				hold_ticket <= hold_ticket + 1;
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = draw_page_request(phase_pages[phase] + 8);
				send_page_request(r, 1'b0, '0);
				if (phase == 3 && n == ITEMS_PER_PHASE / 2)
					wait_results_drained();
			end
		end

		wait_results_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
